@@ design/assert_macros.svh @@
// Assertion helpers used by the a85_checker module.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define A85_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define A85_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/a85_pkg.sv @@
package a85_pkg;

	typedef enum logic [1:0] {
		ACT_DATA  = 2'd0,
		ACT_FLUSH = 2'd1,
		ACT_EOS   = 2'd2,
		ACT_NONE  = 2'd3
	} a85_action_t;

	localparam logic [6:0] CHAR_Z       = 7'h7A;
	localparam logic [6:0] CHAR_TILDE   = 7'h7E;
	localparam logic [6:0] CHAR_GT      = 7'h3E;
	localparam logic [6:0] CHAR_NL      = 7'h0A;
	localparam logic [6:0] DIGIT_OFFSET = 7'd33;
	localparam logic [31:0] RADIX       = 32'd85;

	// ceil(2^38 / 85); q = (v * RECIP_85) >> 38 is exact for any 32-bit v.
	localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
	localparam int          RECIP_SHIFT = 38;
	localparam int          QUOT_W      = 64 - RECIP_SHIFT;

	localparam int          GROUP_BYTES = 4;
	localparam int          NUM_DIGITS  = GROUP_BYTES + 1;
	localparam logic [2:0]  FULL_COUNT  = 3'(GROUP_BYTES);
	localparam logic [2:0]  CONV_LAST   = 3'(NUM_DIGITS);

	localparam logic [9:0]  ROW_LENGTH_RESET = 10'd72;

	localparam int          FIFO_DEPTH = 4;
	localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

	// Work handed from the front end to the converter.
	typedef struct packed {
		logic [31:0] value;  // group, left aligned and zero padded
		logic [2:0]  cnt;    // bytes in the group, zero when there is none
		logic        flush;
		logic        eos;
	} a85_job_t;

	// Converted group handed to the character emitter.
	typedef struct packed {
		logic [NUM_DIGITS-1:0][6:0] dig;  // dig[0] is the most significant
		logic [2:0]                 cnt;
		logic                       flush;
		logic                       eos;
		logic                       zero;
	} a85_pkt_t;

endpackage

@@ design/a85_fifo.sv @@
module a85_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  a85_pkg::a85_job_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output a85_pkg::a85_job_t head
);

	a85_pkg::a85_job_t                 mem_q [a85_pkg::FIFO_DEPTH];
	logic [a85_pkg::FIFO_AW-1:0]       wp_q;
	logic [a85_pkg::FIFO_AW-1:0]       rp_q;
	logic [a85_pkg::FIFO_AW:0]         cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign full       = (cnt_q == (a85_pkg::FIFO_AW + 1)'(a85_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

@@ design/a85_front.sv @@
module a85_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic [1:0]       s_tuser,
	output logic             job_push,
	output a85_pkg::a85_job_t job,
	input  logic             q_full
);

	// Bytes of the open group, right aligned; at most three stay open.
	logic [23:0]           pg_q;
	logic [1:0]            pc_q;
	logic [23:0]           pg_d;
	logic [1:0]            pc_d;
	logic                  gen;
	logic                  accept;
	a85_pkg::a85_action_t  act;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign act      = a85_pkg::a85_action_t'(s_tuser);
	assign job_push = accept && gen;

	always_comb begin
		gen       = 1'b0;
		pg_d      = pg_q;
		pc_d      = pc_q;
		job.value = '0;
		job.cnt   = '0;
		job.flush = 1'b0;
		job.eos   = 1'b0;
		unique case (act)
			a85_pkg::ACT_DATA, a85_pkg::ACT_FLUSH: begin
				gen       = (pc_q == 2'd3) || (act == a85_pkg::ACT_FLUSH);
				job.cnt   = {1'b0, pc_q} + 3'd1;
				job.flush = (act == a85_pkg::ACT_FLUSH);
				unique case (pc_q)
					2'd0: job.value = {s_tdata, 24'h0};
					2'd1: job.value = {pg_q[7:0], s_tdata, 16'h0};
					2'd2: job.value = {pg_q[15:0], s_tdata, 8'h0};
					2'd3: job.value = {pg_q[23:0], s_tdata};
					default: job.value = '0;
				endcase
				if (gen) begin
					pg_d = '0;
					pc_d = '0;
				end else begin
					pg_d = {pg_q[15:0], s_tdata};
					pc_d = pc_q + 2'd1;
				end
			end
			a85_pkg::ACT_EOS: begin
				gen       = 1'b1;
				job.cnt   = {1'b0, pc_q};
				job.flush = 1'b1;
				job.eos   = 1'b1;
				unique case (pc_q)
					2'd0: job.value = '0;
					2'd1: job.value = {pg_q[7:0], 24'h0};
					2'd2: job.value = {pg_q[15:0], 16'h0};
					2'd3: job.value = {pg_q[23:0], 8'h0};
					default: job.value = '0;
				endcase
				pg_d = '0;
				pc_d = '0;
			end
			default: begin
				gen = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q <= '0;
			pc_q <= '0;
		end else if (accept) begin
			pg_q <= pg_d;
			pc_q <= pc_d;
		end
	end

endmodule

@@ design/a85_conv.sv @@
module a85_conv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  a85_pkg::a85_job_t job,
	output logic             job_pop,
	output logic             pkt_valid,
	output a85_pkg::a85_pkt_t pkt,
	input  logic             pkt_take
);

	// One base-85 digit per cycle, least significant first, through a
	// reciprocal multiply whose product is registered before use.
	logic                            busy_q;
	logic                            done_q;
	logic [2:0]                      step_q;
	logic [31:0]                     cur_q;
	logic [63:0]                     prod_q;
	logic [a85_pkg::QUOT_W-1:0]      quot;
	logic [31:0]                     mul_in;
	logic [31:0]                     rem;
	logic [6:0]                      digit;

	assign quot    = prod_q[63:a85_pkg::RECIP_SHIFT];
	assign mul_in  = (step_q == '0) ? cur_q : 32'(quot);
	assign rem     = cur_q - 32'(32'(quot) * a85_pkg::RADIX);
	assign digit   = rem[6:0] + a85_pkg::DIGIT_OFFSET;
	assign job_pop = job_valid && !busy_q && (!done_q || pkt_take);
	assign pkt_valid = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (pkt_take) begin
				done_q <= 1'b0;
			end
			if (job_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == a85_pkg::CONV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q     <= job.value;
			pkt.cnt   <= job.cnt;
			pkt.flush <= job.flush;
			pkt.eos   <= job.eos;
			pkt.zero  <= (job.value == '0);
		end else if (busy_q) begin
			prod_q <= {32'd0, mul_in} * {32'd0, a85_pkg::RECIP_85};
			if (step_q != '0) begin
				cur_q   <= 32'(quot);
				pkt.dig <= {pkt.dig[a85_pkg::NUM_DIGITS-2:0], digit};
			end
		end
	end

endmodule

@@ design/a85_emit.sv @@
module a85_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [9:0]       cfg_wdata,
	input  logic             pkt_valid,
	input  a85_pkg::a85_pkt_t pkt,
	output logic             pkt_take,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [6:0]       out_char,
	output logic             out_last
);

	typedef enum logic [5:0] {
		E_IDLE  = 6'b000001,
		E_GRP   = 6'b000010,
		E_NL    = 6'b000100,
		E_TILDE = 6'b001000,
		E_GT    = 6'b010000,
		E_END   = 6'b100000
	} emit_state_t;

	emit_state_t        st_q;
	emit_state_t        st_d;
	a85_pkg::a85_pkt_t  pk_q;
	logic [2:0]         idx_q;
	logic [10:0]        lc_q;
	logic [10:0]        lc_d;
	logic [10:0]        lc_inc;
	logic [9:0]         row_q;
	logic               out_valid_q;
	logic [6:0]         out_char_q;
	logic               out_last_q;
	logic               advance;
	logic               emit;
	logic [6:0]         ch;
	logic               last;
	logic               is_z;
	logic               grp_end;
	logic               nl_need;

	assign m_tvalid = out_valid_q;
	assign out_char = out_char_q;
	assign out_last = out_last_q;
	assign advance  = !out_valid_q || m_tready;
	assign pkt_take = (st_q == E_IDLE) && pkt_valid;
	assign lc_inc   = lc_q + 11'd1;
	assign is_z     = (pk_q.cnt == a85_pkg::FULL_COUNT) && pk_q.zero;
	assign grp_end  = is_z || (idx_q == pk_q.cnt);
	assign nl_need  = pk_q.flush || (lc_inc >= {1'b0, row_q});

	always_comb begin
		st_d = st_q;
		lc_d = lc_q;
		emit = 1'b0;
		ch   = a85_pkg::CHAR_NL;
		last = 1'b0;
		unique case (st_q)
			E_IDLE: begin
				if (pkt_valid) begin
					if (pkt.cnt != '0) begin
						st_d = E_GRP;
					end else if (lc_q != '0) begin
						st_d = E_NL;
					end else begin
						st_d = E_TILDE;
					end
				end
			end
			E_GRP: begin
				emit = 1'b1;
				ch   = is_z ? a85_pkg::CHAR_Z : pk_q.dig[idx_q];
				last = grp_end && !nl_need && !pk_q.eos;
				lc_d = lc_inc;
				if (grp_end) begin
					if (nl_need) begin
						st_d = E_NL;
					end else if (pk_q.eos) begin
						st_d = E_TILDE;
					end else begin
						st_d = E_IDLE;
					end
				end
			end
			E_NL: begin
				emit = 1'b1;
				ch   = a85_pkg::CHAR_NL;
				last = !pk_q.eos;
				lc_d = '0;
				st_d = pk_q.eos ? E_TILDE : E_IDLE;
			end
			E_TILDE: begin
				emit = 1'b1;
				ch   = a85_pkg::CHAR_TILDE;
				st_d = E_GT;
			end
			E_GT: begin
				emit = 1'b1;
				ch   = a85_pkg::CHAR_GT;
				st_d = E_END;
			end
			E_END: begin
				emit = 1'b1;
				ch   = a85_pkg::CHAR_NL;
				last = 1'b1;
				st_d = E_IDLE;
			end
			default: begin
				st_d = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= E_IDLE;
			lc_q        <= '0;
			idx_q       <= '0;
			row_q       <= a85_pkg::ROW_LENGTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				row_q <= cfg_wdata;
			end
			if (pkt_take) begin
				st_q  <= st_d;
				idx_q <= '0;
			end else if (emit && advance) begin
				st_q  <= st_d;
				lc_q  <= lc_d;
				idx_q <= idx_q + 3'd1;
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			pk_q <= pkt;
		end
		if (emit && advance) begin
			out_char_q <= ch;
			out_last_q <= last;
		end
	end

endmodule

@@ design/ascii85_line_encoder_top.sv @@
// Throughput: one input byte per cycle until the four-entry job queue fills; after that
// conversion and output pace the input, with six converter steps per group plus handoff.
// Output: one character per cycle while a group plays out and m_tready does not stall it,
// set by the emitter sequencer.
// Reset: arst_n clears pending bytes, line count, queue and handshakes; row_length is 72.
module ascii85_line_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: row_length write.
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	// Input stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [1:0] s_tuser,   // [1:0] action
	// Output stream.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] character, [7] zero
	output logic       m_tlast
);

	// The front end keeps the open group of up to three bytes. A byte that
	// completes a group, a flush byte, or an end-of-stream transaction turns
	// into one job: the group left aligned and zero padded, its byte count and
	// the flush and end flags. Bytes that only extend the open group take no
	// queue slot, so the input side runs at one byte per cycle while the queue is not full.
	a85_pkg::a85_job_t f_job;
	logic              f_push;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	a85_pkg::a85_job_t q_head;
	a85_pkg::a85_pkt_t c_pkt;
	logic              c_valid;
	logic              e_take;
	logic [6:0]        e_char;

	a85_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.job_push (f_push),
		.job      (f_job),
		.q_full   (q_full)
	);

	// A short queue lets the input side run ahead while the back end is busy
	// converting or while the output side is stalled.
	a85_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_push),
		.push_data  (f_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// The converter produces the five base-85 digits of one group, one digit
	// per cycle, and holds them until the emitter takes the packet. It starts
	// on the next job while the emitter is still sending the previous one.
	a85_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_head),
		.job_pop   (q_pop),
		.pkt_valid (c_valid),
		.pkt       (c_pkt),
		.pkt_take  (e_take)
	);

	// The emitter walks through the characters of a packet: 'z' or count+1
	// digits, the line break when the line is full or a flush asks for it,
	// and the "~>" trailer on end of stream. It owns the line count and the
	// row_length register, and drives the output register that decouples the
	// sequencer from m_tready.
	a85_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pkt_valid (c_valid),
		.pkt       (c_pkt),
		.pkt_take  (e_take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_char  (e_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, e_char};

endmodule

@@ design/a85_checker.sv @@
`include "assert_macros.svh"

module a85_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	`A85_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output valid dropped while stalled")
	`A85_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
	`A85_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7] == 1'b0, "padding bit of output set")
	`A85_ASSERT_NOW(a_tilde_not_last, m_tvalid && m_tdata[6:0] == a85_pkg::CHAR_TILDE, !m_tlast, "tilde marked last")
	`A85_ASSERT_NEXT(a_tilde_then_gt, m_tvalid && m_tready && m_tdata[6:0] == a85_pkg::CHAR_TILDE, m_tvalid && m_tdata[6:0] == a85_pkg::CHAR_GT, "tilde not followed by '>'")

endmodule

bind ascii85_line_encoder_top a85_checker u_a85_checker (.*);

@@ verif/ascii85_line_checker.sv @@
`timescale 1ns / 100ps

module ascii85_line_checker
	import a85_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [1:0] s_tuser,   // [1:0] action
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [6:0] character, [7] zero
	input  logic       m_tlast,
	output int         fail_count,
	output int         outstanding
);

	typedef struct packed {
		logic [6:0] ch;
		logic       tail;
	} out_char_t;

	// Encoder state as the block should hold it.
	logic [9:0]  row_len;
	logic [31:0] group_bytes;
	logic [2:0]  group_fill;
	logic [10:0] line_len;

	out_char_t expected_chars[$];
	out_char_t burst[$];
	int        mismatches = 0;
	int        queued = 0;

	assign fail_count  = mismatches;
	assign outstanding = queued;

	task automatic note_mismatch(input string what);
		mismatches++;
		$display("%0t ns ascii85 output mismatch: %s", $time, what);
	endtask

	task automatic put_char(input logic [6:0] ch);
		out_char_t c;
		c.ch   = ch;
		c.tail = 1'b0;
		burst.push_back(c);
	endtask

	// Closes the open group: 'z' for a full zero group, otherwise count+1
	// base-85 digits of the right-padded value, then an optional line break.
	task automatic close_group(input bit flush);
		logic [31:0] value;
		logic [6:0]  digit [NUM_DIGITS];
		int          n;
		n = (group_fill > FULL_COUNT) ? GROUP_BYTES : int'(group_fill);
		value = group_bytes << (8 * (GROUP_BYTES - n));
		if (n == GROUP_BYTES && value == 32'd0) begin
			put_char(CHAR_Z);
			line_len = line_len + 11'd1;
		end else begin
			for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
				digit[i] = 7'(value % RADIX) + DIGIT_OFFSET;
				value = value / RADIX;
			end
			for (int i = 0; i <= n; i++) put_char(digit[i]);
			line_len = line_len + 11'(n + 1);
		end
		group_bytes = '0;
		group_fill  = '0;
		if (line_len >= {1'b0, row_len} || flush) begin
			put_char(CHAR_NL);
			line_len = '0;
		end
	endtask

	task automatic encode_item(input a85_action_t act, input logic [7:0] value);
		out_char_t last_char;
		burst.delete();
		case (act)
			ACT_DATA, ACT_FLUSH: begin
				group_bytes = {group_bytes[23:0], value};
				group_fill  = group_fill + 3'd1;
				if (group_fill >= FULL_COUNT || act == ACT_FLUSH) close_group(act == ACT_FLUSH);
			end
			ACT_EOS: begin
				if (group_fill != '0) close_group(1'b1);
				if (line_len != '0) begin
					put_char(CHAR_NL);
					line_len = '0;
				end
				put_char(CHAR_TILDE);
				put_char(CHAR_GT);
				put_char(CHAR_NL);
			end
			default: begin
			end
		endcase
		if (burst.size() > 0) begin
			last_char = burst.pop_back();
			last_char.tail = 1'b1;
			burst.push_back(last_char);
		end
		foreach (burst[i]) expected_chars.push_back(burst[i]);
	endtask

	task automatic check_char();
		out_char_t want;
		if (expected_chars.size() == 0) begin
			note_mismatch($sformatf("character 0x%02h with nothing expected", m_tdata));
		end else begin
			want = expected_chars.pop_front();
			if (m_tdata[6:0] !== want.ch)
				note_mismatch($sformatf("character 0x%02h, expected 0x%02h",
					m_tdata[6:0], want.ch));
			if (m_tdata[7] !== 1'b0)
				note_mismatch("padding bit of the character is not zero");
			if (m_tlast !== want.tail)
				note_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.tail));
		end
	endtask

	// Outputs are compared before new work is queued, so a character that
	// leaves in the same cycle as an input arrives is matched against older work.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len     = ROW_LENGTH_RESET;
			group_bytes = '0;
			group_fill  = '0;
			line_len    = '0;
			expected_chars.delete();
			queued <= 0;
		end else begin
			if (m_tvalid && m_tready) check_char();
			if (cfg_we) row_len = cfg_wdata;
			if (s_tvalid && s_tready) encode_item(a85_action_t'(s_tuser), s_tdata);
			queued <= expected_chars.size();
		end
	end

endmodule

@@ verif/tb_ascii85_line_encoder_top.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the ASCII85 line encoder. The checker instance
// beside the block predicts every character and compares it; this module only
// drives transactions, changes the row length between phases and decides.
module tb_ascii85_line_encoder_top;
	import a85_pkg::*;

	localparam int RANDOM_ITEMS  = 250;
	localparam int PHASES        = 5;
	// Quiet cycles required before a row length write and at the end.
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [9:0] cfg_wdata = '0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic       m_tready = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic       m_tlast;

	int fail_count;
	int outstanding;
	int cycles = 0;
	// Bytes in the open group as seen from the stimulus side; used to line up
	// all-zero groups so that they really turn into 'z'.
	int group_fill = 0;
	// Items that the block acts on; ignored actions are not counted.
	int sent = 0;
	// When set, neither side idles.
	bit calm = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	ascii85_line_encoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ascii85_line_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// The character receiver stalls about a quarter of the time unless calm.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 25);
	end

	// A hung handshake or a lost character ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_ascii85_line_encoder_top: FAIL");
			$finish;
		end
	end

	// Offers one transaction and returns at the edge where it is taken. tvalid
	// stays high on return so that back-to-back transactions need no gap; it
	// is only lowered when the sender decides to idle. tready depends only on
	// registers, so its value at the falling edge is the one the next rising
	// edge sees.
	task automatic send_item(input a85_action_t act, input logic [7:0] value);
		bit taken;
		while (!calm && $urandom_range(99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= act;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		case (act)
			ACT_DATA: group_fill = (group_fill + 1) % GROUP_BYTES;
			ACT_FLUSH, ACT_EOS: group_fill = 0;
			default: begin
			end
		endcase
		if (act != ACT_NONE) sent++;
	endtask

	// Drops tvalid and waits until no character has been owed for a while.
	task automatic settle();
		int quiet;
		quiet = 0;
		s_tvalid <= 1'b0;
		while (quiet < SETTLE_CYCLES) begin
			@(posedge clk);
			quiet = (outstanding == 0) ? quiet + 1 : 0;
		end
	endtask

	task automatic write_row_length(input logic [9:0] value);
		settle();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Zero and all-ones bytes are favored since they steer the encoding.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r < 3) return 8'h00;
		if (r == 3) return 8'hFF;
		return 8'($urandom());
	endfunction

	// Mostly plain data bytes, with zero groups, flushes, stream ends and a
	// few unused actions mixed in.
	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			for (int k = group_fill; k < GROUP_BYTES; k++) send_item(ACT_DATA, 8'h00);
		end else if (r < 65) begin
			send_item(ACT_DATA, pick_byte());
		end else if (r < 80) begin
			send_item(ACT_FLUSH, pick_byte());
		end else if (r < 92) begin
			send_item(ACT_EOS, pick_byte());
		end else begin
			send_item(ACT_NONE, pick_byte());
		end
	endtask

	initial begin
		logic [9:0] row_setting [PHASES];
		int         base;
		// Zero row length breaks the line after every group; the others cover
		// the widest, the narrowest and a couple of ordinary lengths.
		row_setting = '{10'd0, 10'd1023, 10'd1, 10'd9, 10'd72};
		row_setting[PHASES-1] = 10'($urandom_range(2, 1022));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part at the reset row length of 72.
		// A stream end with nothing pending and an empty line.
		send_item(ACT_EOS, 8'hC3);
		// The unused action must be ignored.
		send_item(ACT_NONE, 8'hA5);
		// A full zero group becomes 'z'.
		repeat (4) send_item(ACT_DATA, 8'h00);
		// A partial zero group must still be sent as digits.
		send_item(ACT_DATA, 8'h00);
		send_item(ACT_FLUSH, 8'h00);
		// The largest group value.
		repeat (4) send_item(ACT_DATA, 8'hFF);
		// An unused action in the middle of a group leaves it untouched.
		send_item(ACT_DATA, 8'h12);
		send_item(ACT_NONE, 8'hFF);
		send_item(ACT_DATA, 8'h34);
		send_item(ACT_FLUSH, 8'h56);
		// A stream end flushes a one-byte group.
		send_item(ACT_DATA, 8'h80);
		send_item(ACT_EOS, 8'h00);
		// A single byte with flush.
		send_item(ACT_FLUSH, 8'h7F);
		// A full group leaves the line open; the stream end must close it.
		send_item(ACT_DATA, 8'h01);
		send_item(ACT_DATA, 8'h02);
		send_item(ACT_DATA, 8'h03);
		send_item(ACT_DATA, 8'h04);
		send_item(ACT_EOS, 8'hFF);
		send_item(ACT_EOS, 8'h5A);

		// Random phases, each at its own row length. The middle phase runs
		// without any idling on either side.
		base = sent;
		for (int p = 0; p < PHASES; p++) begin
			write_row_length(row_setting[p]);
			calm = (p == 2);
			while (sent - base < (p + 1) * RANDOM_ITEMS / PHASES) random_item();
		end
		calm = 1'b0;

		settle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb_ascii85_line_encoder_top: PASS");
		end else begin
			$display("tb_ascii85_line_encoder_top: FAIL");
		end
		$finish;
	end

endmodule
